FILE: sv/rsp_pkg.sv
// shared types and constants for the resp2 stream parser
// no dependencies
package rsp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic CFG_MAX_BULK  = 1'b0;
  localparam logic CFG_MAX_ARRAY = 1'b1;

  localparam logic [29:0] MAX_BULK_RST  = 30'd536870912;
  localparam logic [15:0] MAX_ARRAY_RST = 16'd1024;

  typedef enum logic [3:0] {
    CL_PLUS, CL_MINUS, CL_COLON, CL_DOLLAR, CL_STAR, CL_CR, CL_LF, CL_DIGIT, CL_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    EV_PAY    = 3'd0,
    EV_SIMPLE = 3'd1,
    EV_ERR    = 3'd2,
    EV_INT    = 3'd3,
    EV_BULK   = 3'd4,
    EV_NULL   = 3'd5,
    EV_ARR    = 3'd6,
    EV_PROTO  = 3'd7
  } ev_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LINE, PH_NUM, PH_DATA, PH_DCR, PH_DLF
  } ph_t;

  typedef enum logic {
    M_RUN, M_POP
  } mode_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
    cls_t       cls;
  } in_item_t;

  typedef struct packed {
    ev_t         event_res;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic [4:0]  nest_level;
    logic        message_done;
  } out_item_t;

endpackage

FILE: sv/rsp_fifo.sv
// small register queue used on both sides of the parser engine
// no dependencies
module rsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/rsp_front.sv
// front: takes stream bytes, classifies them and queues them for the engine
// depends on rsp_pkg, rsp_fifo
module rsp_front
  import rsp_pkg::*;
#(
  parameter int IN_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] rx_byte,
  input  logic       restart,
  output logic       full,
  input  logic       take,
  output in_item_t   item,
  output logic       empty
);
  in_item_t wr_item;
  cls_t     cls;

  always_comb begin
    case (rx_byte)
      CH_PLUS:   cls = CL_PLUS;
      CH_MINUS:  cls = CL_MINUS;
      CH_COLON:  cls = CL_COLON;
      CH_DOLLAR: cls = CL_DOLLAR;
      CH_STAR:   cls = CL_STAR;
      CH_CR:     cls = CL_CR;
      CH_LF:     cls = CL_LF;
      default:   cls = (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) ? CL_DIGIT : CL_OTHER;
    endcase
    wr_item.rx_byte = rx_byte;
    wr_item.restart = restart;
    wr_item.cls     = cls;
  end

  rsp_fifo #(
    .WIDTH($bits(in_item_t)),
    .DEPTH(IN_DEPTH)
  ) u_in_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(wr_item),
    .full (full),
    .pop  (take),
    .rdata(item),
    .empty(empty)
  );

endmodule

FILE: sv/rsp_engine.sv
// back: parser state, number accumulation, array count stack and limits
// depends on rsp_pkg
module rsp_engine
  import rsp_pkg::*;
#(
  parameter int DEPTH_LIMIT = 16,
  parameter int LVL_W = $clog2(DEPTH_LIMIT + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [29:0]      cfg_wdata,
  input  in_item_t         in_item,
  input  logic             in_empty,
  output logic             in_take,
  output out_item_t        out_item,
  output logic             out_push,
  input  logic             out_full,
  output logic [LVL_W-1:0] level
);
  localparam int STACK_SIZE = DEPTH_LIMIT + 1;
  localparam int SIDX_W = (STACK_SIZE > 1) ? $clog2(STACK_SIZE) : 1;
  localparam logic [67:0] LIM_POS = {5'd0, 63'h7FFF_FFFF_FFFF_FFFF};
  localparam logic [67:0] LIM_NEG = {5'd1, 63'd0};

  logic [29:0]      max_bulk_r;
  logic [15:0]      max_arr_r;
  mode_t            mode_r, mode_nxt;
  ph_t              phase_r, phase_nxt;
  ev_t              kind_r, kind_nxt;
  logic [63:0]      accum_r, accum_nxt;
  logic             neg_r, neg_nxt, dig_r, dig_nxt, sgn_r, sgn_nxt, cr_r, cr_nxt;
  logic [29:0]      rem_r, rem_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_v_r, held_v_nxt;
  logic [LVL_W-1:0] level_r, level_nxt, cur_lvl;
  ev_t              pend_ev_r, pend_ev_nxt;
  logic [63:0]      pend_val_r, pend_val_nxt;
  logic [LVL_W-1:0] pend_lvl_r, pend_lvl_nxt;
  logic [15:0]      stack_r [STACK_SIZE];
  logic             stk_we;
  logic [SIDX_W-1:0] stk_idx, top_idx;
  logic [15:0]      stk_wdata, top_dec;
  logic             go_idle, do_fail, do_finish;
  logic [67:0]      acc_next;
  logic [29:0]      rem_dec;

  assign level    = level_r;
  assign top_idx  = SIDX_W'(level_r - 1'b1);
  assign top_dec  = stack_r[top_idx] - 16'd1;
  assign acc_next = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1)
                    + {64'd0, in_item.rx_byte[3:0]};

  always_comb begin
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    accum_nxt    = accum_r;
    neg_nxt      = neg_r;
    dig_nxt      = dig_r;
    sgn_nxt      = sgn_r;
    cr_nxt       = cr_r;
    rem_nxt      = rem_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    level_nxt    = level_r;
    pend_ev_nxt  = pend_ev_r;
    pend_val_nxt = pend_val_r;
    pend_lvl_nxt = pend_lvl_r;
    stk_we       = 1'b0;
    stk_idx      = top_idx;
    stk_wdata    = top_dec;
    in_take      = 1'b0;
    out_push     = 1'b0;
    out_item     = '0;
    go_idle      = 1'b0;
    do_fail      = 1'b0;
    do_finish    = 1'b0;
    cur_lvl      = level_r;
    rem_dec      = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

    case (mode_r)
      M_POP: begin
        if (!out_full) begin
          out_item.event_res  = pend_ev_r;
          out_item.value      = pend_val_r;
          out_item.nest_level = 5'(pend_lvl_r);
          if (level_r == '0) begin
            out_push                = 1'b1;
            out_item.message_done   = 1'b1;
            mode_nxt                = M_RUN;
          end else if (top_dec != '0) begin
            stk_we   = 1'b1;
            out_push = 1'b1;
            mode_nxt = M_RUN;
          end else begin
            level_nxt = level_r - 1'b1;
          end
        end
      end
      M_RUN: begin
        if (!in_empty && !out_full) begin
          in_take = 1'b1;
          if (in_item.restart) begin
            phase_nxt  = PH_IDLE;
            kind_nxt   = EV_PAY;
            accum_nxt  = '0;
            neg_nxt    = 1'b0;
            dig_nxt    = 1'b0;
            sgn_nxt    = 1'b0;
            cr_nxt     = 1'b0;
            rem_nxt    = '0;
            held_nxt   = '0;
            held_v_nxt = 1'b0;
            level_nxt  = '0;
            cur_lvl    = '0;
          end
          out_item.nest_level = 5'(cur_lvl);
          case (phase_nxt)
            PH_IDLE: begin
              if (cur_lvl > LVL_W'(DEPTH_LIMIT)) begin
                do_fail = 1'b1;
              end else begin
                case (in_item.cls)
                  CL_PLUS: begin
                    kind_nxt = EV_SIMPLE; phase_nxt = PH_LINE;
                  end
                  CL_MINUS: begin
                    kind_nxt = EV_ERR; phase_nxt = PH_LINE;
                  end
                  CL_COLON: begin
                    kind_nxt = EV_INT; phase_nxt = PH_NUM;
                  end
                  CL_DOLLAR: begin
                    kind_nxt = EV_BULK; phase_nxt = PH_NUM;
                  end
                  CL_STAR: begin
                    kind_nxt = EV_ARR; phase_nxt = PH_NUM;
                  end
                  default: do_fail = 1'b1;
                endcase
              end
            end
            PH_LINE: begin
              if (held_v_nxt && held_nxt == CH_CR && in_item.cls == CL_LF) begin
                do_finish   = 1'b1;
                pend_ev_nxt = (kind_nxt == EV_ERR) ? EV_ERR : EV_SIMPLE;
                pend_val_nxt = '0;
              end else if (held_v_nxt) begin
                out_push              = 1'b1;
                out_item.event_res    = EV_PAY;
                out_item.payload_byte = held_nxt;
                held_nxt              = in_item.rx_byte;
              end else begin
                held_nxt   = in_item.rx_byte;
                held_v_nxt = 1'b1;
              end
            end
            PH_NUM: begin
              if (cr_nxt) begin
                if (in_item.cls != CL_LF) begin
                  do_fail = 1'b1;
                end else if (kind_nxt == EV_INT) begin
                  do_finish    = 1'b1;
                  pend_ev_nxt  = EV_INT;
                  pend_val_nxt = neg_nxt ? (64'd0 - accum_nxt) : accum_nxt;
                end else if (neg_nxt && accum_nxt == 64'd1) begin
                  do_finish    = 1'b1;
                  pend_ev_nxt  = EV_NULL;
                  pend_val_nxt = '1;
                end else if (neg_nxt && accum_nxt != '0) begin
                  do_fail = 1'b1;
                end else if (kind_nxt == EV_BULK) begin
                  if (accum_nxt > {34'd0, max_bulk_r}) begin
                    do_fail = 1'b1;
                  end else begin
                    neg_nxt   = 1'b0;
                    dig_nxt   = 1'b0;
                    sgn_nxt   = 1'b0;
                    cr_nxt    = 1'b0;
                    rem_nxt   = accum_nxt[29:0];
                    phase_nxt = (accum_nxt == '0) ? PH_DCR : PH_DATA;
                  end
                end else if (accum_nxt > {48'd0, max_arr_r}) begin
                  do_fail = 1'b1;
                end else if (accum_nxt == '0) begin
                  do_finish    = 1'b1;
                  pend_ev_nxt  = EV_ARR;
                  pend_val_nxt = '0;
                end else if (cur_lvl >= LVL_W'(STACK_SIZE)) begin
                  do_fail = 1'b1;
                end else begin
                  stk_we             = 1'b1;
                  stk_idx            = SIDX_W'(cur_lvl);
                  stk_wdata          = accum_nxt[15:0];
                  level_nxt          = cur_lvl + 1'b1;
                  go_idle            = 1'b1;
                  out_push           = 1'b1;
                  out_item.event_res = EV_ARR;
                  out_item.value     = accum_nxt;
                end
              end else if (in_item.cls == CL_CR) begin
                if (!dig_nxt) begin
                  do_fail = 1'b1;
                end else begin
                  cr_nxt = 1'b1;
                end
              end else if (in_item.cls == CL_PLUS || in_item.cls == CL_MINUS) begin
                if (dig_nxt || sgn_nxt) begin
                  do_fail = 1'b1;
                end else begin
                  sgn_nxt = 1'b1;
                  if (in_item.cls == CL_MINUS) begin
                    neg_nxt = 1'b1;
                  end
                end
              end else if (in_item.cls == CL_DIGIT) begin
                if (acc_next > (neg_nxt ? LIM_NEG : LIM_POS)) begin
                  do_fail = 1'b1;
                end else begin
                  accum_nxt = acc_next[63:0];
                  dig_nxt   = 1'b1;
                end
              end else begin
                do_fail = 1'b1;
              end
            end
            PH_DATA: begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                phase_nxt = PH_DCR;
              end
              out_push              = 1'b1;
              out_item.event_res    = EV_PAY;
              out_item.payload_byte = in_item.rx_byte;
            end
            PH_DCR: begin
              if (in_item.cls != CL_CR) begin
                do_fail = 1'b1;
              end else begin
                phase_nxt = PH_DLF;
              end
            end
            PH_DLF: begin
              if (in_item.cls != CL_LF) begin
                do_fail = 1'b1;
              end else begin
                do_finish    = 1'b1;
                pend_ev_nxt  = EV_BULK;
                pend_val_nxt = accum_nxt;
              end
            end
            default: do_fail = 1'b1;
          endcase

          if (do_fail) begin
            out_push           = 1'b1;
            out_item           = '0;
            out_item.event_res = EV_PROTO;
            out_item.nest_level = 5'(cur_lvl);
            level_nxt          = '0;
            go_idle            = 1'b1;
          end
          if (do_finish) begin
            pend_lvl_nxt = cur_lvl;
            mode_nxt     = M_POP;
            go_idle      = 1'b1;
          end
          if (go_idle) begin
            phase_nxt  = PH_IDLE;
            kind_nxt   = EV_PAY;
            accum_nxt  = '0;
            neg_nxt    = 1'b0;
            dig_nxt    = 1'b0;
            sgn_nxt    = 1'b0;
            cr_nxt     = 1'b0;
            rem_nxt    = '0;
            held_nxt   = '0;
            held_v_nxt = 1'b0;
          end
        end
      end
      default: mode_nxt = M_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bulk_r <= MAX_BULK_RST;
      max_arr_r  <= MAX_ARRAY_RST;
      mode_r     <= M_RUN;
      phase_r    <= PH_IDLE;
      kind_r     <= EV_PAY;
      accum_r    <= '0;
      neg_r      <= 1'b0;
      dig_r      <= 1'b0;
      sgn_r      <= 1'b0;
      cr_r       <= 1'b0;
      rem_r      <= '0;
      held_r     <= '0;
      held_v_r   <= 1'b0;
      level_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_MAX_BULK) begin
        max_bulk_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_MAX_ARRAY) begin
        max_arr_r <= cfg_wdata[15:0];
      end
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      dig_r    <= dig_nxt;
      sgn_r    <= sgn_nxt;
      cr_r     <= cr_nxt;
      rem_r    <= rem_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ev_r  <= pend_ev_nxt;
    pend_val_r <= pend_val_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    if (stk_we) begin
      stack_r[stk_idx] <= stk_wdata;
    end
  end

endmodule

FILE: sv/resp2_stream_parser_core.sv
// top level of the resp2 stream parser: input queue, engine, result queue
// depends on rsp_pkg, rsp_fifo, rsp_front, rsp_engine
// A byte-serial RESP2 parser with queue-style ports on both sides. Most bytes
// are handled in M_RUN; a byte that ends a value switches to M_POP, which walks
// the count stack one level per cycle while the result queue has room, popping
// finished arrays before the result is pushed. Queues of IN_DEPTH and OUT_DEPTH
// words sit in front of and behind the engine, so the input keeps filling while
// a result waits. Configuration writes belong to times when the parser is idle.
module resp2_stream_parser_core
  import rsp_pkg::*;
#(
  parameter int DEPTH_LIMIT = 16,
  parameter int IN_DEPTH    = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_restart,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_res,
  output logic signed [63:0] out_value,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_nest_level,
  output logic        out_message_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [29:0] cfg_wdata
);
  localparam int LVL_W = $clog2(DEPTH_LIMIT + 2);

  in_item_t         q_item;
  logic             q_empty, q_take;
  out_item_t        eng_item, res_item;
  logic             eng_push, res_full;
  logic [LVL_W-1:0] level;

  rsp_front #(.IN_DEPTH(IN_DEPTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .rx_byte(in_rx_byte),
    .restart(in_restart),
    .full   (in_full),
    .take   (q_take),
    .item   (q_item),
    .empty  (q_empty)
  );

  rsp_engine #(.DEPTH_LIMIT(DEPTH_LIMIT), .LVL_W(LVL_W)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (q_item),
    .in_empty (q_empty),
    .in_take  (q_take),
    .out_item (eng_item),
    .out_push (eng_push),
    .out_full (res_full),
    .level    (level)
  );

  rsp_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (eng_push),
    .wdata(eng_item),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_item),
    .empty(out_empty)
  );

  assign out_event_res    = res_item.event_res;
  assign out_value        = res_item.value;
  assign out_payload_byte = res_item.payload_byte;
  assign out_nest_level   = res_item.nest_level;
  assign out_message_done = res_item.message_done;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LVL_W'(DEPTH_LIMIT + 1))
    else $error("stack level beyond stack size");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_full |-> !eng_push)
    else $error("engine pushed into a full result queue");

  a_proto_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_res == EV_PROTO) |-> !out_message_done)
    else $error("protocol error marked as message end");

  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_res == EV_PAY) |-> (out_value == '0))
    else $error("payload word carries a value");

endmodule
